@@ hw/rtl/gbci_pkg.sv @@
package gbci_pkg;

    // widths of the item fields and of the stored state
    localparam int RATE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int ANGLE_W  = 32;
    localparam int ACC_W    = 64;
    localparam int OFF_W    = 24;
    localparam int SUM_W    = 28;
    localparam int CNT_W    = 10;    // sample counter and calibration count register
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;

    localparam int IN_DATA_W  = 3 * RATE_W + TIME_W;
    localparam int OUT_DATA_W = 3 * ANGLE_W;

    // rate scaling: inc = v * dt * 32 / 1796875, v in Q8 raw LSB
    localparam int RATE_SH  = 5;
    localparam int CAL_SH   = 8;
    localparam int DIV_W    = 21;
    localparam logic [DIV_W-1:0] DEN_RATE = DIV_W'(1796875);

    localparam int VAL_W    = OFF_W + 1;               // raw*256 + offset
    localparam int PROD_W   = VAL_W + TIME_W;          // |v| * dt
    localparam int NUM_W    = 64;                      // divider numerator / quotient

    // divider: RADIX_BITS quotient bits per cycle
    localparam int RADIX_BITS = 4;
    localparam int DIV_STEPS  = NUM_W / RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0] OFF_MAX_Q = NUM_W'(8388607);
    localparam logic [NUM_W-1:0] OFF_MIN_Q = NUM_W'(8388608);

    typedef struct packed {
        logic latch_in;
        logic restart;
        logic cal_acc;
        logic axis_clr;
        logic axis_next;
        logic mul;
        logic load;
        logic div_step;
        logic write;
        logic finish_cal;
        logic latch_time;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd;
        logic in_cal;
        logic cal_done;
        logic later;
        logic last_axis;
    } t_dp_sts;

endpackage

@@ hw/rtl/gyro_bias_calibrate_and_integrate.sv @@
// Gyro bias calibration and rate integration. Each input item carries three raw
// signed 16-bit rates and a microsecond timestamp; tuser high instead restarts:
// angles, sums and count clear and calibration begins. While calibrating, the
// rates are summed per axis until cal_sample_count samples (0 acts as 1) are in;
// then each axis offset becomes minus the rounded average in Q8 LSB and the
// timestamp is latched. In run mode a later timestamp advances each angle by
// (raw + offset) / 14.375 deg/s times the elapsed time, rounded to nearest; an
// older or equal timestamp only gets latched. Every item gives one result: the
// three angles as saturated Q16.16 degrees plus the calibrating flag. A restart,
// a plain calibration sample or a stale timestamp passes only through decode to
// the result; an integrating sample or the sample that completes calibration
// also runs, axis by axis, through one shared multiplier and one divider that
// retires 4 quotient bits per cycle (per axis: multiply, load, 16 divide steps
// and write). One item is in work at a time; the output register lets the next
// item enter while the last result waits to be taken. Write cal_sample_count
// only when idle.
module gyro_bias_calibrate_and_integrate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: cal_sample_count
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // rate_x[15:0], rate_y[31:16], rate_z[47:32],
                                       // time_us[79:48]
    input  logic        s_axis_tuser,  // cmd: 1 = restart calibration
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // angle_x[31:0], angle_y[63:32], angle_z[95:64]
    output logic        m_axis_tuser   // calibrating
);

    gbci_pkg::t_dp_cmd w_cmd;
    gbci_pkg::t_dp_sts w_sts;

    gbci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    gbci_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_cmd    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (m_axis_tdata),
        .o_out_cal   (m_axis_tuser)
    );

endmodule

@@ hw/rtl/gbci_ctrl.sv @@
module gbci_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gbci_pkg::t_dp_cmd o_cmd,
    input  gbci_pkg::t_dp_sts i_sts
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    logic [gbci_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.cmd) begin
                    o_cmd.restart = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_sts.in_cal) begin
                    o_cmd.cal_acc  = 1'b1;
                    o_cmd.axis_clr = 1'b1;
                    n_state        = i_sts.cal_done ? S_MUL : S_FINISH;
                end else if (i_sts.later) begin
                    o_cmd.axis_clr = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    o_cmd.latch_time = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == gbci_pkg::STEP_W'(gbci_pkg::DIV_STEPS - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_sts.last_axis) begin
                    // last axis: leave calibration or just take the new timestamp
                    o_cmd.finish_cal = i_sts.in_cal;
                    o_cmd.latch_time = !i_sts.in_cal;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.axis_next = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // no item taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/gbci_dp.sv @@
module gbci_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbci_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_cmd,
    input  logic [gbci_pkg::IN_DATA_W-1:0]      i_in_data,
    input  gbci_pkg::t_dp_cmd                   i_cmd,
    output gbci_pkg::t_dp_sts                   o_sts,
    output logic [gbci_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic                                o_out_cal
);

    localparam int RW = gbci_pkg::RATE_W;
    localparam int DW = gbci_pkg::DIV_W;
    localparam int NW = gbci_pkg::NUM_W;
    localparam int AW = gbci_pkg::ACC_W;

    function automatic logic [gbci_pkg::ANGLE_W-1:0] sat_angle(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = {{(AW-gbci_pkg::ANGLE_W+1){1'b0}}, {(gbci_pkg::ANGLE_W-1){1'b1}}};
        lo = {{(AW-gbci_pkg::ANGLE_W+1){1'b1}}, {(gbci_pkg::ANGLE_W-1){1'b0}}};
        if (a > hi) begin
            sat_angle = hi[gbci_pkg::ANGLE_W-1:0];
        end else if (a < lo) begin
            sat_angle = lo[gbci_pkg::ANGLE_W-1:0];
        end else begin
            sat_angle = a[gbci_pkg::ANGLE_W-1:0];
        end
    endfunction

    // configuration and item latch
    logic [gbci_pkg::CNT_W-1:0]         r_cfg;
    logic                               r_cmd;
    logic signed [RW-1:0]               r_rate [gbci_pkg::AXES];
    logic [gbci_pkg::TIME_W-1:0]        r_time;

    // architectural state
    logic signed [AW-1:0]               r_angle  [gbci_pkg::AXES];
    logic signed [gbci_pkg::OFF_W-1:0]  r_offset [gbci_pkg::AXES];
    logic signed [gbci_pkg::SUM_W-1:0]  r_sum    [gbci_pkg::AXES];
    logic [gbci_pkg::CNT_W-1:0]         r_count;
    logic                               r_in_cal;
    logic [gbci_pkg::TIME_W-1:0]        r_last_time;

    // shared multiply / divide path
    logic [gbci_pkg::AXIS_W-1:0]        r_axis;
    logic [gbci_pkg::PROD_W-1:0]        r_prod;
    logic                               r_neg;
    logic [NW-1:0]                      r_num;
    logic [DW:0]                        r_rem;
    logic [DW-1:0]                      r_div;

    logic [gbci_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic                               r_out_cal;

    logic [gbci_pkg::CNT_W-1:0]         w_target;
    logic [gbci_pkg::CNT_W-1:0]         w_count_inc;
    logic [gbci_pkg::TIME_W-1:0]        w_dt;
    logic signed [gbci_pkg::VAL_W-1:0]  w_v;
    logic [gbci_pkg::VAL_W-1:0]         w_mag_v;
    logic signed [gbci_pkg::SUM_W-1:0]  w_sum_sel;
    logic [gbci_pkg::SUM_W-1:0]         w_mag_sum;
    logic [gbci_pkg::PROD_W-1:0]        w_prod_run;
    logic [DW-1:0]                      w_div_sel;
    logic [NW-1:0]                      w_num_sel;
    logic [DW:0]                        n_rem;
    logic [NW-1:0]                      n_num;
    logic signed [gbci_pkg::OFF_W-1:0]  w_off_new;
    logic signed [AW-1:0]               w_inc;
    logic signed [AW:0]                 w_acc_sum;
    logic signed [AW-1:0]               w_acc_new;

    assign w_target    = (r_cfg == '0) ? gbci_pkg::CNT_W'(1) : r_cfg;
    assign w_count_inc = r_count + 1'b1;
    assign w_dt        = r_time - r_last_time;

    assign w_v = {{1{r_rate[r_axis][RW-1]}}, r_rate[r_axis], 8'b0}
               + {r_offset[r_axis][gbci_pkg::OFF_W-1], r_offset[r_axis]};
    assign w_mag_v    = w_v[gbci_pkg::VAL_W-1] ? -w_v : w_v;
    assign w_sum_sel  = r_sum[r_axis];
    assign w_mag_sum  = w_sum_sel[gbci_pkg::SUM_W-1] ? -w_sum_sel : w_sum_sel;
    assign w_prod_run = w_mag_v * w_dt;

    assign w_div_sel = r_in_cal ? DW'(w_target) : gbci_pkg::DEN_RATE;
    assign w_num_sel = (r_in_cal ? NW'(r_prod) : NW'({r_prod, {gbci_pkg::RATE_SH{1'b0}}}))
                     + NW'(w_div_sel >> 1);

    // restoring division, RADIX_BITS quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        for (int k = 0; k < gbci_pkg::RADIX_BITS; k++) begin
            n_rem = {n_rem[DW-1:0], n_num[NW-1]};
            n_num = {n_num[NW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_div}) begin
                n_rem    = n_rem - {1'b0, r_div};
                n_num[0] = 1'b1;
            end
        end
    end

    // offset = -(rounded average), clamped to 24 bits
    always_comb begin
        if (r_neg) begin
            w_off_new = (r_num > gbci_pkg::OFF_MAX_Q) ? gbci_pkg::OFF_W'(8388607)
                                                      : r_num[gbci_pkg::OFF_W-1:0];
        end else begin
            w_off_new = (r_num > gbci_pkg::OFF_MIN_Q) ? gbci_pkg::OFF_W'(8388608)
                                                      : -r_num[gbci_pkg::OFF_W-1:0];
        end
    end

    // saturating angle update
    assign w_inc     = r_neg ? -$signed(r_num) : $signed(r_num);
    assign w_acc_sum = {r_angle[r_axis][AW-1], r_angle[r_axis]} + {w_inc[AW-1], w_inc};
    always_comb begin
        if (w_acc_sum[AW] != w_acc_sum[AW-1]) begin
            w_acc_new = w_acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            w_acc_new = w_acc_sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= gbci_pkg::CNT_W'(300);
            r_count     <= '0;
            r_in_cal    <= 1'b0;
            r_last_time <= '0;
            r_axis      <= '0;
            for (int a = 0; a < gbci_pkg::AXES; a++) begin
                r_angle[a]  <= '0;
                r_offset[a] <= '0;
                r_sum[a]    <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.restart) begin
                for (int a = 0; a < gbci_pkg::AXES; a++) begin
                    r_angle[a] <= '0;
                    r_sum[a]   <= '0;
                end
                r_count  <= '0;
                r_in_cal <= 1'b1;
            end
            if (i_cmd.cal_acc) begin
                for (int a = 0; a < gbci_pkg::AXES; a++) begin
                    r_sum[a] <= r_sum[a] + gbci_pkg::SUM_W'(r_rate[a]);
                end
                r_count <= w_count_inc;
            end
            if (i_cmd.axis_clr) begin
                r_axis <= '0;
            end else if (i_cmd.axis_next) begin
                r_axis <= r_axis + 1'b1;
            end
            if (i_cmd.write) begin
                if (r_in_cal) begin
                    r_offset[r_axis] <= w_off_new;
                end else begin
                    r_angle[r_axis] <= w_acc_new;
                end
            end
            if (i_cmd.finish_cal) begin
                r_in_cal    <= 1'b0;
                r_last_time <= r_time;
            end
            if (i_cmd.latch_time) begin
                r_last_time <= r_time;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd     <= i_in_cmd;
            r_rate[0] <= i_in_data[RW-1:0];
            r_rate[1] <= i_in_data[2*RW-1:RW];
            r_rate[2] <= i_in_data[3*RW-1:2*RW];
            r_time    <= i_in_data[gbci_pkg::IN_DATA_W-1:3*RW];
        end
        if (i_cmd.mul) begin
            if (r_in_cal) begin
                r_prod <= gbci_pkg::PROD_W'({w_mag_sum, {gbci_pkg::CAL_SH{1'b0}}});
                r_neg  <= w_sum_sel[gbci_pkg::SUM_W-1];
            end else begin
                r_prod <= w_prod_run;
                r_neg  <= w_v[gbci_pkg::VAL_W-1];
            end
        end
        if (i_cmd.load) begin
            r_num <= w_num_sel;
            r_rem <= '0;
            r_div <= w_div_sel;
        end else if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {sat_angle(r_angle[2]), sat_angle(r_angle[1]),
                           sat_angle(r_angle[0])};
            r_out_cal  <= r_in_cal;
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.in_cal    = r_in_cal;
    assign o_sts.cal_done  = (w_count_inc >= w_target);
    assign o_sts.later     = (r_time > r_last_time);
    assign o_sts.last_axis = (r_axis == gbci_pkg::AXIS_W'(gbci_pkg::AXES - 1));

    assign o_out_data = r_out_data;
    assign o_out_cal  = r_out_cal;

endmodule

@@ verif/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbci_pkg::*;

    // ------------------------------------------------------------------
    // run shape
    // ------------------------------------------------------------------
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 1_000_000;  // many times the slowest legal run
    localparam int RANDOM_ITEMS  = 540;
    localparam int DRAIN_CYCLES  = 80;         // longer than an integrating item takes
    localparam int HOLD_AT       = 150;        // results seen before the long stall
    localparam int HOLD_CYCLES   = 400;

    // tuser codes on the input side
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;   // always ready
    localparam int RX_COIN   = 1;   // ready half the time
    localparam int RX_SPARSE = 2;   // ready a quarter of the time

    localparam int unsigned CAL_MAX_TARGET  = (1 << CNT_W) - 1;
    localparam int unsigned LONG_CAL_TARGET = 300;   // reset value of the register

    // fixed-point constants for the angle predictor
    localparam longint Q8_ONE    = longint'(1) << CAL_SH;
    localparam longint RATE_GAIN = longint'(1) << RATE_SH;
    localparam longint RATE_DEN  = longint'(DEN_RATE);
    localparam longint OFF_HI    = (longint'(1) << (OFF_W - 1)) - 1;
    localparam longint OFF_LO    = -(longint'(1) << (OFF_W - 1));
    localparam longint ANG_HI    = (longint'(1) << (ANGLE_W - 1)) - 1;
    localparam longint ANG_LO    = -(longint'(1) << (ANGLE_W - 1));

    // one input item; rate[0] is x and sits lowest, as on the bus
    typedef struct packed {
        logic                         cmd;
        logic [TIME_W-1:0]            stamp;
        logic [AXES-1:0][RATE_W-1:0]  rate;
    } t_gyro_item;

    // one result item: {tuser, tdata}
    typedef struct packed {
        logic                         calibrating;
        logic [AXES-1:0][ANGLE_W-1:0] angle;
    } t_angle_result;

    // ------------------------------------------------------------------
    // Angle predictor and result checker.
    // Tracks offsets, calibration sums and integrated angles; one
    // expected result per accepted item, checked in order.
    // ------------------------------------------------------------------
    class gyro_angle_board;
        logic [CNT_W-1:0]  cal_target;
        longint            angle_acc [AXES];
        longint            bias_q8 [AXES];
        longint            rate_sum [AXES];
        int unsigned       sample_cnt;
        bit                calibrating;
        logic [TIME_W-1:0] last_stamp;
        t_angle_result     expected_angles [$];
        string             axis_name [AXES];
        int                errors;

        function new();
            int i;
            cal_target = CNT_W'(300);
            for (i = 0; i < AXES; i++) begin
                angle_acc[i] = 0;
                bias_q8[i]   = 0;
                rate_sum[i]  = 0;
            end
            sample_cnt  = 0;
            calibrating = 0;
            last_stamp  = '0;
            errors      = 0;
            axis_name   = '{"angle_x", "angle_y", "angle_z"};
        endfunction

        function void set_cal_target(logic [CNT_W-1:0] value);
            cal_target = value;
        endfunction

        // nearest, ties away from zero; den > 0
        function longint round_div(longint num, longint den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : num;
            q = (mag + longint'(den / 2)) / longint'(den);
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint sat_add(longint a, longint b);
            logic signed [64:0] s;
            s = a + b;
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function logic [ANGLE_W-1:0] clip_angle(longint a);
            if (a > ANG_HI) return ANG_HI[ANGLE_W-1:0];
            if (a < ANG_LO) return ANG_LO[ANGLE_W-1:0];
            return a[ANGLE_W-1:0];
        endfunction

        function void note_item(t_gyro_item it);
            longint        raw [AXES];
            longint        v;
            longint        dt;
            longint        off;
            int unsigned   tgt;
            int            i;
            t_angle_result want;
            for (i = 0; i < AXES; i++)
                raw[i] = longint'($signed(it.rate[i]));
            if (it.cmd == CMD_RESTART) begin
                // rates and stamp ignored; offsets survive until recalibrated
                for (i = 0; i < AXES; i++) begin
                    angle_acc[i] = 0;
                    rate_sum[i]  = 0;
                end
                sample_cnt  = 0;
                calibrating = 1;
            end else if (calibrating) begin
                tgt = (cal_target == 0) ? 1 : cal_target;
                if (tgt > CAL_MAX_TARGET) tgt = CAL_MAX_TARGET;
                for (i = 0; i < AXES; i++)
                    rate_sum[i] += raw[i];
                sample_cnt = (sample_cnt + 1) & CAL_MAX_TARGET;
                // >= so a target lowered mid-calibration ends it at once
                if (sample_cnt >= tgt) begin
                    for (i = 0; i < AXES; i++) begin
                        off = -round_div(rate_sum[i] * Q8_ONE, longint'(tgt));
                        if (off > OFF_HI) off = OFF_HI;
                        if (off < OFF_LO) off = OFF_LO;
                        bias_q8[i] = off;
                    end
                    calibrating = 0;
                    last_stamp  = it.stamp;   // completing sample does not integrate
                end
            end else begin
                // stale or wrapped stamp: latch only
                if (it.stamp > last_stamp) begin
                    dt = longint'(it.stamp) - longint'(last_stamp);
                    for (i = 0; i < AXES; i++) begin
                        v = raw[i] * Q8_ONE + bias_q8[i];
                        angle_acc[i] = sat_add(angle_acc[i],
                                               round_div(v * dt * RATE_GAIN, RATE_DEN));
                    end
                end
                last_stamp = it.stamp;
            end
            for (i = 0; i < AXES; i++)
                want.angle[i] = clip_angle(angle_acc[i]);
            want.calibrating = calibrating;
            expected_angles.push_back(want);
        endfunction

        function void check_angles(t_angle_result got);
            t_angle_result want;
            int            i;
            if (expected_angles.size() == 0) begin
                errors++;
                $error("unexpected result: angle_x %0d angle_y %0d angle_z %0d",
                       $signed(got.angle[0]), $signed(got.angle[1]),
                       $signed(got.angle[2]));
                return;
            end
            want = expected_angles.pop_front();
            for (i = 0; i < AXES; i++) begin
                if (got.angle[i] !== want.angle[i]) begin
                    errors++;
                    $error("%s: expected %0d, actual %0d", axis_name[i],
                           $signed(want.angle[i]), $signed(got.angle[i]));
                end
            end
            if (got.calibrating !== want.calibrating) begin
                errors++;
                $error("calibrating: expected %0d, actual %0d",
                       want.calibrating, got.calibrating);
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [9:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // rate_x, rate_y, rate_z, time_us (low to high)
    logic        s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // angle_x, angle_y, angle_z (low to high)
    logic        m_axis_tuser;   // calibrating

    gyro_bias_calibrate_and_integrate uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    gyro_angle_board   board;
    int                results_seen;
    int                burst_left;
    bit                steady;          // no input gaps for this phase
    logic [TIME_W-1:0] cur_stamp;
    int                axis_bias [AXES];

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("gyro_bias_calibrate_and_integrate regression: fail");
        $finish;
    end

    // result monitor: sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_angles({m_axis_tuser, m_axis_tdata});
            results_seen++;
        end
    end

    // Receiver: stall pattern changes after each span of random length. Once,
    // after HOLD_AT results, it holds off for HOLD_CYCLES so the block backs up
    // and drops s_axis_tready while the sender keeps offering.
    initial begin
        int mode;
        int span;
        bit held;
        held = 0;
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(RX_SPARSE, RX_OPEN);
            span = $urandom_range(200, 20);
            repeat (span) begin
                @(negedge i_clk);
                if (!held && results_seen >= HOLD_AT) begin
                    m_axis_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    held = 1;
                end
                case (mode)
                    RX_OPEN: begin
                        m_axis_tready = 1'b1;
                    end
                    RX_COIN: begin
                        m_axis_tready = $urandom_range(1, 0);
                    end
                    default: begin
                        m_axis_tready = ($urandom_range(3, 0) == 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one item from the next falling edge until it is taken
    task automatic push_item(t_gyro_item it);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {it.stamp, it.rate};
        s_axis_tuser  = it.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(it);
    endtask

    task automatic pause_input(int cycles);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // bursts of random length, with random gaps between them when not steady
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            if (!steady && $urandom_range(3, 0) != 0)
                pause_input($urandom_range(12, 1));
        end
        burst_left--;
    endtask

    // register write only with nothing outstanding
    task automatic write_cal_target(logic [CNT_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        board.set_cal_target(value);
    endtask

    function automatic t_gyro_item mk(logic cmd, logic [RATE_W-1:0] rx,
                                      logic [RATE_W-1:0] ry, logic [RATE_W-1:0] rz,
                                      logic [TIME_W-1:0] stamp);
        t_gyro_item it;
        it.cmd     = cmd;
        it.rate[0] = rx;
        it.rate[1] = ry;
        it.rate[2] = rz;
        it.stamp   = stamp;
        return it;
    endfunction

    // zero-rate level plus a little noise, now and then anything at all
    function automatic logic [RATE_W-1:0] near_bias(int center);
        int v;
        if ($urandom_range(9, 0) == 0) return RATE_W'($urandom);
        v = center + int'($urandom_range(128, 0)) - 64;
        return RATE_W'(v);
    endfunction

    function automatic void new_biases();
        int i;
        for (i = 0; i < AXES; i++) begin
            if ($urandom_range(9, 0) == 0)
                axis_bias[i] = $urandom_range(1, 0) ? 32700 : -32700;
            else
                axis_bias[i] = int'($urandom_range(4000, 0)) - 2000;
        end
    endfunction

    // Mostly well-formed: calibration samples near the bias, then run
    // samples with advancing stamps; a few restarts, stale stamps, jumps.
    function automatic t_gyro_item make_item(bit allow_restart);
        t_gyro_item it;
        int         pick;
        int         i;
        it.cmd = CMD_SAMPLE;
        if (allow_restart && $urandom_range(99, 0) < 3) begin
            it.cmd = CMD_RESTART;
            for (i = 0; i < AXES; i++) it.rate[i] = RATE_W'($urandom);
            it.stamp = $urandom;
            return it;
        end
        if (board.calibrating) begin
            for (i = 0; i < AXES; i++) it.rate[i] = near_bias(axis_bias[i]);
            cur_stamp += $urandom_range(150, 100);
        end else begin
            for (i = 0; i < AXES; i++)
                it.rate[i] = $urandom_range(1, 0) ? near_bias(axis_bias[i])
                                                  : RATE_W'($urandom);
            pick = $urandom_range(99, 0);
            if (pick < 84)      cur_stamp += $urandom_range(400, 1);
            else if (pick < 94) cur_stamp -= $urandom_range(1000, 0);
            else if (pick < 97) cur_stamp += $urandom;
            else                cur_stamp = $urandom;
        end
        it.stamp = cur_stamp;
        return it;
    endfunction

    // field extremes, stale/equal/wrapped stamps, restart in and out of
    // calibration, offset clipping, target lowered mid-calibration
    task automatic run_directed();
        push_item(mk(CMD_SAMPLE,  16'h7FFF, 16'h8000, 16'h0000, 32'd1000));
        push_item(mk(CMD_SAMPLE,  16'h0001, 16'hFFFF, 16'h5555, 32'd1000));  // equal stamp
        push_item(mk(CMD_SAMPLE,  16'hAAAA, 16'h7FFF, 16'h0001, 32'd400));   // older stamp
        push_item(mk(CMD_SAMPLE,  16'h8000, 16'h7FFF, 16'd12345, 32'hFFFF_FFFF));
        push_item(mk(CMD_SAMPLE,  16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd5));     // wrapped
        push_item(mk(CMD_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        push_item(mk(CMD_SAMPLE,  16'h8000, 16'h7FFF, 16'd100, 32'd1500));
        // completes: x offset clips at the positive limit
        push_item(mk(CMD_SAMPLE,  16'h8000, 16'h7FFF, 16'd101, 32'd2000));
        push_item(mk(CMD_SAMPLE,  16'h0000, 16'h0000, 16'h0000, 32'd2125));
        push_item(mk(CMD_SAMPLE,  16'h8000, 16'h7FFF, 16'hFFFF, 32'd2250));
        push_item(mk(CMD_RESTART, 16'h0000, 16'h0000, 16'h0000, 32'd0));
        push_item(mk(CMD_SAMPLE,  16'h7FFF, 16'h8000, 16'h0000, 32'd10));
        push_item(mk(CMD_RESTART, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA));
        push_item(mk(CMD_SAMPLE,  16'h7FFF, 16'h8000, 16'h1234, 32'd20));
        // completes: y offset clips at the positive limit
        push_item(mk(CMD_SAMPLE,  16'h7FFF, 16'h8000, 16'h1235, 32'd30));
        push_item(mk(CMD_SAMPLE,  16'h7FFF, 16'h8000, 16'h4321, 32'd155));
        push_item(mk(CMD_SAMPLE,  16'h0000, 16'hFFFF, 16'h0001, 32'h8000_0000));
        write_cal_target(CNT_W'(5));
        push_item(mk(CMD_RESTART, 16'h1111, 16'h2222, 16'h3333, 32'h5555_5555));
        push_item(mk(CMD_SAMPLE,  16'h0010, 16'hFFF0, 16'h0003, 32'd100));
        push_item(mk(CMD_SAMPLE,  16'h0011, 16'hFFF1, 16'h0004, 32'd200));
        push_item(mk(CMD_SAMPLE,  16'h0012, 16'hFFF2, 16'h0005, 32'd300));
        // target drops below the count already reached: next sample ends it
        write_cal_target(CNT_W'(2));
        push_item(mk(CMD_SAMPLE,  16'h0013, 16'hFFF3, 16'h0006, 32'd400));
        push_item(mk(CMD_SAMPLE,  16'h0100, 16'hFF00, 16'h0007, 32'd525));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int               done;
        int               phase;
        int               phase_len;
        int               pick;
        logic [CNT_W-1:0] target;

        board         = new();
        results_seen  = 0;
        burst_left    = 0;
        steady        = 1;
        cur_stamp     = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SAMPLE;
        m_axis_tready = 1'b0;
        new_biases();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_cal_target(CNT_W'(2));
        run_directed();

        // reset-value target: a long calibration, then some run samples
        write_cal_target(CNT_W'(LONG_CAL_TARGET));
        steady = 0;
        new_biases();
        push_item(mk(CMD_RESTART, 16'h0000, 16'h0000, 16'h0000, 32'd0));
        repeat (LONG_CAL_TARGET + 40) begin
            pace();
            push_item(make_item(1'b0));
        end

        // random phases; a phase may end mid-calibration so the next
        // target takes effect on a half-filled sum
        done  = 0;
        phase = 0;
        while (done < RANDOM_ITEMS) begin
            pick = $urandom_range(99, 0);
            if (phase == 0)      target = '0;
            else if (phase == 1) target = CNT_W'(1);
            else if (pick < 70)  target = CNT_W'($urandom_range(24, 1));
            else if (pick < 80)  target = '0;
            else if (pick < 90)  target = CNT_W'(1);
            else                 target = CNT_W'($urandom_range(120, 25));
            write_cal_target(target);
            steady = ($urandom_range(3, 0) == 0);
            new_biases();
            if ($urandom_range(1, 0) != 0)
                push_item(make_item(1'b0) | {1'b1, {(TIME_W + AXES * RATE_W){1'b0}}});
            phase_len = $urandom_range(80, 20);
            repeat (phase_len) begin
                pace();
                push_item(make_item(1'b1));
                done++;
            end
            phase++;
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("gyro_bias_calibrate_and_integrate regression: pass");
        else
            $display("gyro_bias_calibrate_and_integrate regression: fail");
        $finish;
    end

endmodule

@@ gyro_bias_calibrate_and_integrate.f @@
hw/rtl/gbci_pkg.sv
hw/rtl/gbci_ctrl.sv
hw/rtl/gbci_dp.sv
hw/rtl/gyro_bias_calibrate_and_integrate.sv
verif/tb.sv
